// File: rtl/mbg_pkg.sv
// Package for the maze carver: field widths, operation and status codes,
// register indexes and default sizes. No dependencies.
package mbg_pkg;

    // default storage sizes
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_STACK_DEPTH = 1024;

    // channel field widths
    localparam int OP_W     = 2;
    localparam int RND_W    = 16;
    localparam int CRD_W    = 6;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     DIM_RESET       = 7'd16;
    localparam int                   DIM_MIN         = 5;

    // operations; the remaining codes read a cell
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;

    // result status
    localparam logic [STATUS_W-1:0] ST_CARVED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BACKTRACK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FINISHED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REPORT    = 2'd3;

    // carving stride between cells
    localparam int CARVE_STRIDE = 2;

endpackage

// File: rtl/mbg_if.sv
// Valid/ready channel interfaces for the maze carver: request and result.
// Depends on mbg_pkg for field widths.
interface mbg_in_if;
    logic                          valid;
    logic                          ready;
    logic [mbg_pkg::OP_W-1:0]      operation;
    logic [mbg_pkg::RND_W-1:0]     random_value;
    logic [mbg_pkg::CRD_W-1:0]     read_col;
    logic [mbg_pkg::CRD_W-1:0]     read_row;

    modport source (output valid, operation, random_value, read_col, read_row,
                    input ready);
    modport sink   (input valid, operation, random_value, read_col, read_row,
                    output ready);
endinterface

interface mbg_out_if;
    logic                          valid;
    logic                          ready;
    logic [mbg_pkg::STATUS_W-1:0]  status;
    logic [mbg_pkg::CRD_W-1:0]     cell_col;
    logic [mbg_pkg::CRD_W-1:0]     cell_row;
    logic                          is_wall;

    modport source (output valid, status, cell_col, cell_row, is_wall,
                    input ready);
    modport sink   (input valid, status, cell_col, cell_row, is_wall,
                    output ready);
endinterface

// File: rtl/mbg_grid_mem.sv
// One-bit wall grid memory: one write port, one read port, registered read.
// No dependencies.
module mbg_grid_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mbg_stack_mem.sv
// Cell stack memory: one write port, one read port, registered read.
// No dependencies.
module mbg_stack_mem #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 12,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/maze_backtracker_generator.sv
// Maze carver top level: sequencer around the wall grid and cell stack.
// Depends on mbg_pkg, mbg_if, mbg_grid_mem and mbg_stack_mem.
// Usage: requests arrive on in_ch (valid/ready), one result per request
// leaves on out_ch (valid/ready). A transaction on either side completes
// when valid and ready are both high at a rising edge of clk.
// Operations: start (clear grid to wall, push cell (1, height-2)),
// carving step (open top cell, probe four neighbors, carve or pop),
// read (report one cell). grid_width and grid_height must be written by the
// user via cfg_we/cfg_index/cfg_wdata while idle; the block does not check.
// Work per request:
//   carving step      stack read, four grid reads, one decision
//   step, empty stack  finished status, no memory access
//   read               one grid read
//   start              whole grid cleared, one grid entry per cycle
// The single grid read port sets the step length: one neighbor per cycle.
// After reset the grid is swept to wall with
// in_ch.ready low; configuration writes are taken during the sweep.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, the next result waits in the sequencer
// until the output register frees.
module maze_backtracker_generator #(
    parameter int MAX_COLS    = mbg_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = mbg_pkg::DEF_MAX_ROWS,
    parameter int STACK_DEPTH = mbg_pkg::DEF_STACK_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mbg_in_if.sink                         in_ch,
    mbg_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]      cfg_wdata
);

    import mbg_pkg::*;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int GRID_CELLS = MAX_COLS * MAX_ROWS;
    localparam int GADDR_W    = $clog2(GRID_CELLS);
    localparam int SADDR_W    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
    localparam int SENT_W     = COL_W + ROW_W;
    localparam int WC_W       = $clog2(MAX_COLS + 1);
    localparam int WR_W       = $clog2(MAX_ROWS + 1);
    localparam int CC_W       = (COL_W + 2 > CRD_W + 1) ? COL_W + 2 : CRD_W + 1;
    localparam int RC_W       = (ROW_W + 2 > CRD_W + 1) ? ROW_W + 2 : CRD_W + 1;
    localparam int KC_W       = ((WC_W > CFG_W) ? WC_W : CFG_W) + 1;
    localparam int KR_W       = ((WR_W > CFG_W) ? WR_W : CFG_W) + 1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;
    localparam logic [2:0] NBR_LAST  = 3'd4;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_TOP    = 9'b000000100,
        S_OPEN   = 9'b000001000,
        S_NBR    = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_READ   = 9'b001000000,
        S_RDATA  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    function automatic logic [GADDR_W-1:0] cell_addr(input int r, input int c);
        return GADDR_W'(r * MAX_COLS + c);
    endfunction

    // 4 == 1 (mod 3): fold 2-bit digits until the value is below 3
    function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < RND_W / 2; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        if (u >= 3'd3)
        begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

    // registers
    state_t                 state_reg, state_next;
    logic [GADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                   start_flag_reg, start_flag_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [CFG_W-1:0]       grid_width_reg, grid_width_next;
    logic [CFG_W-1:0]       grid_height_reg, grid_height_next;
    logic                   out_valid_reg, out_valid_next;

    logic [COL_W-1:0]       cx_reg, cx_next;
    logic [ROW_W-1:0]       cy_reg, cy_next;
    logic [RND_W-1:0]       rnd_reg, rnd_next;
    logic [1:0]             mod3_reg, mod3_next;
    logic [2:0]             nbr_idx_reg, nbr_idx_next;
    logic                   inb_prev_reg, inb_prev_next;
    logic [3:0]             cand_reg, cand_next;
    logic [CRD_W-1:0]       rd_col_reg, rd_col_next;
    logic [CRD_W-1:0]       rd_row_reg, rd_row_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [CRD_W-1:0]       res_col_reg, res_col_next;
    logic [CRD_W-1:0]       res_row_reg, res_row_next;
    logic                   res_wall_reg, res_wall_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [CRD_W-1:0]       out_col_reg, out_col_next;
    logic [CRD_W-1:0]       out_row_reg, out_row_next;
    logic                   out_wall_reg, out_wall_next;

    // memory ports
    logic                   grid_we;
    logic [GADDR_W-1:0]     grid_waddr;
    logic                   grid_wdata;
    logic [GADDR_W-1:0]     grid_raddr;
    logic                   grid_rdata;
    logic                   stk_we;
    logic [SADDR_W-1:0]     stk_waddr;
    logic [SENT_W-1:0]      stk_wdata;
    logic [SADDR_W-1:0]     stk_raddr;
    logic [SENT_W-1:0]      stk_rdata;

    // derived values
    logic                   in_accept;
    logic                   out_load;
    logic [KC_W-1:0]        wcfg_ext;
    logic [KR_W-1:0]        hcfg_ext;
    logic [WC_W-1:0]        w_eff;
    logic [WR_W-1:0]        h_eff;
    logic [CC_W-1:0]        cxe, we_ext;
    logic [RC_W-1:0]        cye, he_ext;
    logic [COL_W-1:0]       nb_col [4];
    logic [ROW_W-1:0]       nb_row [4];
    logic                   nb_in  [4];
    logic [GADDR_W-1:0]     nb_addr [4];
    logic [2:0]             cand_cnt;
    logic [1:0]             pick_idx;
    logic [1:0]             pick_dir;
    logic [COL_W-1:0]       bt_col;
    logic [ROW_W-1:0]       bt_row;

    mbg_grid_mem #(
        .DEPTH  (GRID_CELLS),
        .ADDR_W (GADDR_W)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    mbg_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .WIDTH  (SENT_W),
        .ADDR_W (SADDR_W)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign in_accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.cell_col = out_col_reg;
    assign out_ch.cell_row = out_row_reg;
    assign out_ch.is_wall  = out_wall_reg;

    // effective grid size, clamped to [5, max]
    assign wcfg_ext = KC_W'(grid_width_reg);
    assign hcfg_ext = KR_W'(grid_height_reg);

    always_comb
    begin
        if (wcfg_ext < KC_W'(DIM_MIN))
            w_eff = WC_W'(DIM_MIN);
        else if (wcfg_ext > KC_W'(MAX_COLS))
            w_eff = WC_W'(MAX_COLS);
        else
            w_eff = WC_W'(wcfg_ext);

        if (hcfg_ext < KR_W'(DIM_MIN))
            h_eff = WR_W'(DIM_MIN);
        else if (hcfg_ext > KR_W'(MAX_ROWS))
            h_eff = WR_W'(MAX_ROWS);
        else
            h_eff = WR_W'(hcfg_ext);
    end

    // neighbors two cells away, order up, left, right, down
    assign cxe    = CC_W'(cx_reg);
    assign cye    = RC_W'(cy_reg);
    assign we_ext = CC_W'(w_eff);
    assign he_ext = RC_W'(h_eff);

    always_comb
    begin
        nb_col[DIR_UP]    = cx_reg;
        nb_row[DIR_UP]    = cy_reg - ROW_W'(CARVE_STRIDE);
        nb_in[DIR_UP]     = (cxe < we_ext) && (cye >= RC_W'(CARVE_STRIDE))
                            && (cye - RC_W'(CARVE_STRIDE) < he_ext);

        nb_col[DIR_LEFT]  = cx_reg - COL_W'(CARVE_STRIDE);
        nb_row[DIR_LEFT]  = cy_reg;
        nb_in[DIR_LEFT]   = (cye < he_ext) && (cxe >= CC_W'(CARVE_STRIDE))
                            && (cxe - CC_W'(CARVE_STRIDE) < we_ext);

        nb_col[DIR_RIGHT] = cx_reg + COL_W'(CARVE_STRIDE);
        nb_row[DIR_RIGHT] = cy_reg;
        nb_in[DIR_RIGHT]  = (cye < he_ext) && (cxe + CC_W'(CARVE_STRIDE) < we_ext);

        nb_col[DIR_DOWN]  = cx_reg;
        nb_row[DIR_DOWN]  = cy_reg + ROW_W'(CARVE_STRIDE);
        nb_in[DIR_DOWN]   = (cxe < we_ext) && (cye + RC_W'(CARVE_STRIDE) < he_ext);

        for (int k = 0; k < 4; k++)
        begin
            nb_addr[k] = cell_addr(int'(nb_row[k]), int'(nb_col[k]));
        end
    end

    // choose the candidate at index random mod count
    always_comb
    begin
        logic [2:0] seen;
        seen     = '0;
        pick_dir = DIR_UP;
        cand_cnt = 3'($countones(cand_reg));
        case (cand_cnt)
            3'd2:    pick_idx = {1'b0, rnd_reg[0]};
            3'd3:    pick_idx = mod3_reg;
            3'd4:    pick_idx = rnd_reg[1:0];
            default: pick_idx = 2'd0;
        endcase
        for (int k = 0; k < 4; k++)
        begin
            if (cand_reg[k])
            begin
                if (seen == {1'b0, pick_idx})
                    pick_dir = 2'(k);
                seen = seen + 3'd1;
            end
        end

        bt_col = cx_reg;
        bt_row = cy_reg;
        case (pick_dir)
            DIR_UP:    bt_row = cy_reg - ROW_W'(1);
            DIR_LEFT:  bt_col = cx_reg - COL_W'(1);
            DIR_RIGHT: bt_col = cx_reg + COL_W'(1);
            DIR_DOWN:  bt_row = cy_reg + ROW_W'(1);
            default:   bt_col = cx_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        start_flag_next  = start_flag_reg;
        depth_next       = depth_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        out_valid_next   = out_valid_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        rnd_next         = rnd_reg;
        mod3_next        = mod3_reg;
        nbr_idx_next     = nbr_idx_reg;
        inb_prev_next    = inb_prev_reg;
        cand_next        = cand_reg;
        rd_col_next      = rd_col_reg;
        rd_row_next      = rd_row_reg;
        res_status_next  = res_status_reg;
        res_col_next     = res_col_reg;
        res_row_next     = res_row_reg;
        res_wall_next    = res_wall_reg;
        out_status_next  = out_status_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        out_wall_next    = out_wall_reg;
        out_load         = 1'b0;

        grid_we    = 1'b0;
        grid_waddr = '0;
        grid_wdata = 1'b0;
        grid_raddr = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_next  = cfg_wdata;
                CFG_GRID_HEIGHT: grid_height_next = cfg_wdata;
                default:         grid_width_next  = grid_width_reg;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                grid_we    = 1'b1;
                grid_waddr = clr_cnt_reg;
                grid_wdata = 1'b1;
                if (clr_cnt_reg == GADDR_W'(GRID_CELLS - 1))
                begin
                    clr_cnt_next    = '0;
                    start_flag_next = 1'b0;
                    state_next      = start_flag_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + GADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_ch.operation)
                        OP_START:
                        begin
                            stk_we          = 1'b1;
                            stk_waddr       = '0;
                            stk_wdata       = {ROW_W'(h_eff - WR_W'(CARVE_STRIDE)),
                                               COL_W'(1)};
                            depth_next      = DEPTH_W'(1);
                            res_status_next = ST_REPORT;
                            res_col_next    = CRD_W'(1);
                            res_row_next    = CRD_W'(h_eff - WR_W'(CARVE_STRIDE));
                            res_wall_next   = 1'b1;
                            start_flag_next = 1'b1;
                            clr_cnt_next    = '0;
                            state_next      = S_CLEAR;
                        end
                        OP_STEP:
                        begin
                            rnd_next = in_ch.random_value;
                            if (depth_reg == '0)
                            begin
                                res_status_next = ST_FINISHED;
                                res_col_next    = '0;
                                res_row_next    = '0;
                                res_wall_next   = 1'b0;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_TOP;
                            end
                        end
                        default:
                        begin
                            rd_col_next = in_ch.read_col;
                            rd_row_next = in_ch.read_row;
                            state_next  = S_READ;
                        end
                    endcase
                end
            end

            S_TOP:
            begin
                stk_raddr  = SADDR_W'(depth_reg - DEPTH_W'(1));
                state_next = S_OPEN;
            end

            S_OPEN:
            begin
                cx_next      = stk_rdata[COL_W-1:0];
                cy_next      = stk_rdata[COL_W +: ROW_W];
                grid_we      = 1'b1;
                grid_waddr   = cell_addr(int'(stk_rdata[COL_W +: ROW_W]),
                                         int'(stk_rdata[COL_W-1:0]));
                grid_wdata   = 1'b0;
                mod3_next    = mod3_16(rnd_reg);
                cand_next    = '0;
                nbr_idx_next = '0;
                state_next   = S_NBR;
            end

            // one neighbor read issued per cycle, its data lands in the next cycle
            S_NBR:
            begin
                if (nbr_idx_reg != NBR_LAST)
                begin
                    grid_raddr    = nb_addr[nbr_idx_reg[1:0]];
                    inb_prev_next = nb_in[nbr_idx_reg[1:0]];
                end
                if (nbr_idx_reg != '0)
                begin
                    cand_next[2'(nbr_idx_reg - 3'd1)] = grid_rdata & inb_prev_reg;
                end
                if (nbr_idx_reg == NBR_LAST)
                    state_next = S_DECIDE;
                else
                    nbr_idx_next = nbr_idx_reg + 3'd1;
            end

            S_DECIDE:
            begin
                res_col_next  = CRD_W'(cx_reg);
                res_row_next  = CRD_W'(cy_reg);
                res_wall_next = 1'b0;
                if ((cand_reg != '0) && (depth_reg < DEPTH_W'(STACK_DEPTH)))
                begin
                    grid_we         = 1'b1;
                    grid_waddr      = cell_addr(int'(bt_row), int'(bt_col));
                    grid_wdata      = 1'b0;
                    stk_we          = 1'b1;
                    stk_waddr       = SADDR_W'(depth_reg);
                    stk_wdata       = {nb_row[pick_dir], nb_col[pick_dir]};
                    depth_next      = depth_reg + DEPTH_W'(1);
                    res_status_next = ST_CARVED;
                end
                else
                begin
                    depth_next      = depth_reg - DEPTH_W'(1);
                    res_status_next = ST_BACKTRACK;
                end
                state_next = S_FINISH;
            end

            S_READ:
            begin
                grid_raddr    = cell_addr(int'(rd_row_reg), int'(rd_col_reg));
                inb_prev_next = (CC_W'(rd_col_reg) < we_ext) &&
                                (RC_W'(rd_row_reg) < he_ext);
                state_next    = S_RDATA;
            end

            S_RDATA:
            begin
                res_status_next = ST_REPORT;
                res_col_next    = rd_col_reg;
                res_row_next    = rd_row_reg;
                res_wall_next   = inb_prev_reg ? grid_rdata : 1'b1;
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_col_next    = res_col_reg;
            out_row_next    = res_row_reg;
            out_wall_next   = res_wall_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            start_flag_reg  <= 1'b0;
            depth_reg       <= '0;
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
            out_valid_reg   <= 1'b0;
            nbr_idx_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            start_flag_reg  <= start_flag_next;
            depth_reg       <= depth_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            out_valid_reg   <= out_valid_next;
            nbr_idx_reg     <= nbr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        rnd_reg        <= rnd_next;
        mod3_reg       <= mod3_next;
        inb_prev_reg   <= inb_prev_next;
        cand_reg       <= cand_next;
        rd_col_reg     <= rd_col_next;
        rd_row_reg     <= rd_row_next;
        res_status_reg <= res_status_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        res_wall_reg   <= res_wall_next;
        out_status_reg <= out_status_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_wall_reg   <= out_wall_next;
    end

endmodule
